// ===== src/assert_macros.svh =====
// Assertion macros shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCCS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCCS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mccs_pkg.sv =====
// Types and constants shared by the microcoded control sequencer modules.
package mccs_pkg;

    // Input word operations.
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_WR_MC    = 3'd1;
    localparam logic [2:0] OP_WR_MODE  = 3'd2;
    localparam logic [2:0] OP_WR_OP    = 3'd3;
    localparam logic [2:0] OP_RESET    = 3'd4;

    // Result word actions.
    localparam logic [2:0] ACT_SET_MAR    = 3'd0;
    localparam logic [2:0] ACT_MEM_TO_MBR = 3'd1;
    localparam logic [2:0] ACT_CAPTURE_IR = 3'd2;
    localparam logic [2:0] ACT_CONTROL    = 3'd3;
    localparam logic [2:0] ACT_NONE       = 3'd4;

    // Sequencer phases.
    localparam logic [1:0] PH_INIT  = 2'd0;
    localparam logic [1:0] PH_FETCH = 2'd1;
    localparam logic [1:0] PH_ADDR  = 2'd2;
    localparam logic [1:0] PH_OPER  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_BP_ENABLE  = 3'd0;
    localparam logic [2:0] REG_BP_PC      = 3'd1;
    localparam logic [2:0] REG_FETCH_DONE = 3'd2;
    localparam logic [2:0] REG_ADDR_DONE  = 3'd3;
    localparam logic [2:0] REG_PC_INC     = 3'd4;
    localparam logic [2:0] REG_PC_TO_MAR  = 3'd5;
    localparam logic [2:0] REG_MAR_STRIP  = 3'd6;

    // Marker for a bad micro address, micro word or instruction.
    localparam logic [7:0] BAD_VALUE = 8'hFF;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  table_index;
        logic [31:0] table_data;
        logic [7:0]  fetched_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] control_word;
        logic [7:0]  mar_value;
        logic [1:0]  phase;
        logic [7:0]  program_counter;
        logic [7:0]  instruction;
        logic [7:0]  micro_address;
        logic        phase_done;
        logic        program_complete;
        logic        breakpoint_hit;
        logic        error_flag;
        logic        last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       accept;
        logic       step_begin;
        logic       do_fetch;
        logic       dec_rd;
        logic       dec_load;
        logic       mc_rd;
        logic       exec;
        logic       emit;
        logic [1:0] emit_idx;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] phase;
        logic       entering;
        logic       halted;
        logic [1:0] act_count;
    } status_t;

endpackage

// ===== src/mccs_datapath.sv =====
// Datapath of the sequencer: registers, microcode store, decode tables and actions.
`include "assert_macros.svh"

module mccs_datapath import mccs_pkg::*; #(
    parameter int MICROCODE_DEPTH = 256,
    parameter int DECODE_DEPTH    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  cmd_t        cmd,
    output status_t     status,
    output result_t     result
);

    localparam int MA_W = $clog2(MICROCODE_DEPTH);
    localparam int DA_W = $clog2(DECODE_DEPTH);
    localparam logic [8:0] MC_LIMIT  = 9'(MICROCODE_DEPTH);
    localparam logic [8:0] DEC_LIMIT = 9'(DECODE_DEPTH);

    // Configuration registers.
    logic        bp_enable_reg;
    logic [7:0]  bp_pc_reg;
    logic [31:0] fetch_done_reg;
    logic [31:0] addr_done_reg;
    logic [31:0] pc_inc_reg;
    logic [31:0] pc_to_mar_reg;
    logic [31:0] mar_strip_reg;

    // Architectural state.
    logic [1:0]  phase_reg, phase_next;
    logic        entering_reg, entering_next;
    logic [7:0]  pc_reg, pc_next;
    logic [7:0]  ir_reg, ir_next;
    logic [7:0]  maddr_reg, maddr_next;
    logic        halted_reg, halted_next;

    // Step flags and pending actions.
    logic        pdone_reg, pdone_next;
    logic        complete_reg, complete_next;
    logic        brk_reg, brk_next;
    logic [1:0]  count_reg, count_next;
    logic [2:0]  kind0_reg, kind0_next;
    logic [2:0]  kind1_reg, kind1_next;
    logic [2:0]  kind2_reg, kind2_next;
    logic [31:0] word_reg, word_next;
    logic [7:0]  mar_reg, mar_next;

    // Memories and their registered read ports.
    logic [31:0] mc_mem   [MICROCODE_DEPTH];
    logic [7:0]  mode_mem [DECODE_DEPTH];
    logic [7:0]  op_mem   [DECODE_DEPTH];
    logic [31:0] mc_q;
    logic        mc_ok_q;
    logic [7:0]  mode_q;
    logic [7:0]  opt_q;
    logic        dec_ok_q;

    logic [7:0]  dec_val;
    logic [7:0]  mc_addr;
    logic        mc_addr_ok;
    logic        idx_mc_ok;
    logic        idx_dec_ok;
    logic        ir_dec_ok;
    logic [31:0] word_raw;
    logic [31:0] word_eff;
    logic [31:0] done_mask;
    logic        mar_hit;
    logic        word_nz;
    logic        step_err;
    logic        fetch_err;
    logic [2:0]  kind_sel;

    // Address range checks; beyond the depth, writes drop and reads give zero.
    assign idx_mc_ok  = {1'b0, item.table_index} < MC_LIMIT;
    assign idx_dec_ok = {1'b0, item.table_index} < DEC_LIMIT;
    assign ir_dec_ok  = {1'b0, ir_reg} < DEC_LIMIT;
    assign dec_val    = dec_ok_q ? ((phase_reg == PH_ADDR) ? mode_q : opt_q) : 8'd0;
    assign mc_addr    = cmd.dec_load ? dec_val : maddr_reg;
    assign mc_addr_ok = {1'b0, mc_addr} < MC_LIMIT;

    // Microcode store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && item.operation == OP_WR_MC && idx_mc_ok)
        begin
            mc_mem[item.table_index[MA_W-1:0]] <= item.table_data;
        end
        if (cmd.mc_rd)
        begin
            mc_q    <= mc_mem[mc_addr[MA_W-1:0]];
            mc_ok_q <= mc_addr_ok;
        end
    end

    // Decode tables, both read at the instruction register.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && item.operation == OP_WR_MODE && idx_dec_ok)
        begin
            mode_mem[item.table_index[DA_W-1:0]] <= item.table_data[7:0];
        end
        if (cmd.accept && item.operation == OP_WR_OP && idx_dec_ok)
        begin
            op_mem[item.table_index[DA_W-1:0]] <= item.table_data[7:0];
        end
        if (cmd.dec_rd)
        begin
            mode_q   <= mode_mem[ir_reg[DA_W-1:0]];
            opt_q    <= op_mem[ir_reg[DA_W-1:0]];
            dec_ok_q <= ir_dec_ok;
        end
    end

    // Configuration writes; an index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_enable_reg  <= 1'b0;
            bp_pc_reg      <= 8'd0;
            fetch_done_reg <= 32'd0;
            addr_done_reg  <= 32'd0;
            pc_inc_reg     <= 32'd0;
            pc_to_mar_reg  <= 32'd0;
            mar_strip_reg  <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BP_ENABLE:  bp_enable_reg  <= cfg_data[0];
                REG_BP_PC:      bp_pc_reg      <= cfg_data[7:0];
                REG_FETCH_DONE: fetch_done_reg <= cfg_data;
                REG_ADDR_DONE:  addr_done_reg  <= cfg_data;
                REG_PC_INC:     pc_inc_reg     <= cfg_data;
                REG_PC_TO_MAR:  pc_to_mar_reg  <= cfg_data;
                REG_MAR_STRIP:  mar_strip_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Micro word decode: PC routing to MAR, strip, done and increment tests.
    assign word_raw  = mc_ok_q ? mc_q : 32'd0;
    assign mar_hit   = (word_raw & pc_to_mar_reg) == pc_to_mar_reg;
    assign word_eff  = mar_hit ? (word_raw & ~mar_strip_reg) : word_raw;
    assign done_mask = (phase_reg == PH_ADDR) ? addr_done_reg : fetch_done_reg;
    assign word_nz   = word_eff != 32'd0;
    assign step_err  = (maddr_reg == BAD_VALUE) || (word_raw == {24'd0, BAD_VALUE});
    assign fetch_err = item.fetched_byte == BAD_VALUE;

    // Next state of the sequencer for the current command.
    always_comb
    begin
        phase_next    = phase_reg;
        entering_next = entering_reg;
        pc_next       = pc_reg;
        ir_next       = ir_reg;
        maddr_next    = maddr_reg;
        halted_next   = halted_reg;
        pdone_next    = pdone_reg;
        complete_next = complete_reg;
        brk_next      = brk_reg;
        count_next    = count_reg;
        kind0_next    = kind0_reg;
        kind1_next    = kind1_reg;
        kind2_next    = kind2_reg;
        word_next     = word_reg;
        mar_next      = mar_reg;

        if (cmd.accept)
        begin
            pdone_next    = 1'b0;
            complete_next = 1'b0;
            brk_next      = 1'b0;
            count_next    = 2'd1;
            kind0_next    = ACT_NONE;
            if (item.operation == OP_RESET)
            begin
                phase_next    = PH_INIT;
                entering_next = 1'b1;
                pc_next       = 8'd0;
                maddr_next    = 8'd0;
                halted_next   = 1'b0;
            end
            if (cmd.step_begin)
            begin
                entering_next = 1'b0;
            end
            // Fetch tick: three bus actions, IR load and PC increment unless the byte is bad.
            if (cmd.do_fetch)
            begin
                brk_next      = bp_enable_reg && (pc_reg == bp_pc_reg);
                count_next    = 2'd3;
                kind0_next    = ACT_SET_MAR;
                kind1_next    = ACT_MEM_TO_MBR;
                kind2_next    = ACT_CAPTURE_IR;
                mar_next      = pc_reg;
                ir_next       = item.fetched_byte;
                pc_next       = fetch_err ? pc_reg : pc_reg + 8'd1;
                complete_next = item.fetched_byte == 8'd0;
                pdone_next    = 1'b1;
                phase_next    = PH_ADDR;
                entering_next = 1'b1;
                halted_next   = fetch_err;
            end
        end

        // Entry into a phase loads the micro address from a decode table.
        if (cmd.dec_load)
        begin
            maddr_next = dec_val;
        end

        // One micro step on the word read from the store.
        if (cmd.exec)
        begin
            if (step_err)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                if (mar_hit)
                begin
                    kind0_next = ACT_SET_MAR;
                    mar_next   = pc_reg;
                end
                if (word_nz)
                begin
                    if (mar_hit)
                    begin
                        kind1_next = ACT_CONTROL;
                    end
                    else
                    begin
                        kind0_next = ACT_CONTROL;
                    end
                end
                if (mar_hit || word_nz)
                begin
                    count_next = {1'b0, mar_hit} + {1'b0, word_nz};
                end
                word_next = word_eff;
                if ((word_eff & pc_inc_reg) != 32'd0)
                begin
                    pc_next = pc_reg + 8'd1;
                end
                maddr_next = maddr_reg + 8'd1;
                if ((word_eff & done_mask) != 32'd0)
                begin
                    pdone_next    = 1'b1;
                    entering_next = 1'b1;
                    phase_next    = (phase_reg == PH_ADDR) ? PH_OPER : PH_FETCH;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_INIT;
            entering_reg <= 1'b1;
            pc_reg       <= 8'd0;
            ir_reg       <= 8'd0;
            maddr_reg    <= 8'd0;
            halted_reg   <= 1'b0;
            pdone_reg    <= 1'b0;
            complete_reg <= 1'b0;
            brk_reg      <= 1'b0;
            count_reg    <= 2'd1;
        end
        else
        begin
            phase_reg    <= phase_next;
            entering_reg <= entering_next;
            pc_reg       <= pc_next;
            ir_reg       <= ir_next;
            maddr_reg    <= maddr_next;
            halted_reg   <= halted_next;
            pdone_reg    <= pdone_next;
            complete_reg <= complete_next;
            brk_reg      <= brk_next;
            count_reg    <= count_next;
        end
    end

    // Payload registers of the pending actions.
    always_ff @(posedge clk)
    begin
        kind0_reg <= kind0_next;
        kind1_reg <= kind1_next;
        kind2_reg <= kind2_next;
        word_reg  <= word_next;
        mar_reg   <= mar_next;
    end

    // Select the action for the word being sent.
    always_comb
    begin
        case (cmd.emit_idx)
            2'd0:    kind_sel = kind0_reg;
            2'd1:    kind_sel = kind1_reg;
            2'd2:    kind_sel = kind2_reg;
            default: kind_sel = ACT_NONE;
        endcase
    end

    assign result.action           = kind_sel;
    assign result.control_word     = (kind_sel == ACT_CONTROL) ? word_reg : 32'd0;
    assign result.mar_value        = (kind_sel == ACT_SET_MAR) ? mar_reg : 8'd0;
    assign result.phase            = phase_reg;
    assign result.program_counter  = pc_reg;
    assign result.instruction      = ir_reg;
    assign result.micro_address    = maddr_reg;
    assign result.phase_done       = pdone_reg;
    assign result.program_complete = complete_reg;
    assign result.breakpoint_hit   = brk_reg;
    assign result.error_flag       = halted_reg;
    assign result.last             = cmd.emit_idx == (count_reg - 2'd1);

    assign status.phase     = phase_reg;
    assign status.entering  = entering_reg;
    assign status.halted    = halted_reg;
    assign status.act_count = count_reg;

    // Only a reset operation releases a halted sequencer.
    `MCCS_ASSERT_NXT(a_halt_sticky, clk, rst_n,
        halted_reg && !(cmd.accept && item.operation == OP_RESET), halted_reg,
        "halted cleared without a reset operation")
    // A micro step never runs while halted.
    `MCCS_ASSERT_IMP(a_exec_not_halted, clk, rst_n, cmd.exec, !halted_reg,
        "micro step executed while halted")
    // Every step reports at least one word.
    `MCCS_ASSERT_IMP(a_count_nonzero, clk, rst_n, 1'b1, count_reg != 2'd0,
        "pending action count is zero")

endmodule

// ===== src/mccs_ctrl.sv =====
// Controller state machine that sequences each input word through the datapath.
`include "assert_macros.svh"

module mccs_ctrl import mccs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] operation,
    input  status_t    status,
    output logic       busy,
    output cmd_t       cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_EXEC   = 2'd2;
    localparam logic [1:0] S_OUT    = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [1:0] idx_reg, idx_next;
    logic       accept;
    logic       is_tick;
    logic       in_micro_phase;

    assign busy           = state_reg != S_IDLE;
    assign accept         = start && !busy;
    assign is_tick        = operation == OP_TICK && !status.halted;
    assign in_micro_phase = status.phase == PH_ADDR || status.phase == PH_OPER;

    // Command decode and next state.
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd            = '0;
        cmd.emit_idx   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_OUT;
                    if (is_tick && status.phase == PH_FETCH)
                    begin
                        cmd.do_fetch = 1'b1;
                    end
                    else if (is_tick && in_micro_phase && status.entering)
                    begin
                        cmd.step_begin = 1'b1;
                        cmd.dec_rd     = 1'b1;
                        state_next     = S_DECODE;
                    end
                    else if (is_tick)
                    begin
                        cmd.step_begin = 1'b1;
                        cmd.mc_rd      = 1'b1;
                        state_next     = S_EXEC;
                    end
                end
            end
            S_DECODE:
            begin
                cmd.dec_load = 1'b1;
                cmd.mc_rd    = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.emit = 1'b1;
                if (idx_reg == status.act_count - 2'd1)
                begin
                    idx_next   = 2'd0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // An accepted word keeps the unit busy in the next cycle.
    `MCCS_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy,
        "accepted word did not make the unit busy")
    // Every word sent lies within the pending action count.
    `MCCS_ASSERT_IMP(a_emit_in_range, clk, rst_n, cmd.emit,
        cmd.emit_idx < status.act_count, "result index beyond action count")
    // A micro step always follows a microcode store read.
    `MCCS_ASSERT_IMP(a_exec_after_read, clk, rst_n, cmd.exec, $past(cmd.mc_rd),
        "micro step without a preceding store read")

endmodule

// ===== src/microcoded_cpu_control_sequencer_core.sv =====
// Top level of the microcoded CPU control sequencer.
//
//  Channel   Handshake          Payload              Direction
//  item      start / busy       item_t               in
//  config    cfg_we             cfg_index, cfg_data  in
//  result    strobe             result_t             out
//
// A word is taken when start is high and busy is low. Table writes, resets,
// ticks while halted and unknown operations are accepted, then give one result.
// A fetch tick is accepted, then gives three results on the result port.
// A micro step registers a read of the microcode store, executes, then gives one
// or two results; on entry to the address or operation phase a registered read
// of the decode tables comes first. Results are sent at one result per cycle.
// Reset clears all control state; the stores are undefined until written.
// The receiver cannot stall: each result is valid for one cycle with strobe.
module microcoded_cpu_control_sequencer_core import mccs_pkg::*; #(
    parameter int MICROCODE_DEPTH = 256,
    parameter int DECODE_DEPTH    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        strobe,
    output result_t     result
);

    cmd_t    cmd;
    status_t status;

    // Sequencing of each word.
    mccs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (item.operation),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    // State, stores and action generation.
    mccs_datapath #(
        .MICROCODE_DEPTH (MICROCODE_DEPTH),
        .DECODE_DEPTH    (DECODE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign strobe = cmd.emit;

endmodule
